/* rtl/core/ntt_8_point_forward_inverse_defines.svh */
// Assertion helpers shared by the NTT block.
`ifndef NTT_8_POINT_FORWARD_INVERSE_DEFINES_SVH
`define NTT_8_POINT_FORWARD_INVERSE_DEFINES_SVH

// Condition must never hold outside reset.
`define NTT8_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define NTT8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ntt8_pkg.sv */
package ntt8_pkg;

  localparam int POINTS      = 8;
  localparam int LOG_POINTS  = 3;
  localparam int TWIDDLES    = 2 * (POINTS - 1);
  localparam int BFLIES      = (POINTS / 2) * LOG_POINTS;
  localparam int COEFF_BITS  = 24;
  localparam int PROD_BITS   = 2 * COEFF_BITS;
  localparam int QDEPTH      = 2;
  localparam int QPTR_BITS   = $clog2(QDEPTH);

  localparam logic [COEFF_BITS-1:0] MODULUS_RESET  = 24'd17;
  localparam logic [COEFF_BITS-1:0] INVSCALE_RESET = 24'd15;

  // Configuration register indexes.
  localparam logic REG_MODULUS   = 1'b0;
  localparam logic REG_INV_SCALE = 1'b1;

  // Input mode codes.
  localparam logic [1:0] MODE_LOAD_COEFF   = 2'd0;
  localparam logic [1:0] MODE_LOAD_TWIDDLE = 2'd1;
  localparam logic [1:0] MODE_FORWARD      = 2'd2;
  localparam logic [1:0] MODE_INVERSE      = 2'd3;

  typedef logic [COEFF_BITS-1:0] coef_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] slot;
    coef_t      value;
  } in_t;

  typedef struct packed {
    coef_t      coefficient;
    logic [2:0] position;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    OP_LDC,
    OP_LDT,
    OP_FWD,
    OP_INV
  } op_t;

  // One classified command as it waits in the queue.
  typedef struct packed {
    op_t        op;
    logic [3:0] slot;
    coef_t      value;
  } cmd_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_LOAD_MOD,
    B_LOAD_WAIT,
    B_PRE_RD,
    B_PRE_MOD,
    B_PRE_WAIT,
    B_BF_RD,
    B_BF_PREP,
    B_BF_MUL,
    B_BF_MOD,
    B_BF_WAIT,
    B_BF_WR_A,
    B_BF_WR_B,
    B_SC_RD,
    B_SC_MUL,
    B_SC_MOD,
    B_SC_WAIT,
    B_OUT_RD,
    B_OUT_LD
  } bstate_t;

  typedef struct packed {
    logic [2:0] lo;
    logic [2:0] hi;
    logic [3:0] tw;
  } bf_addr_t;

  // Operand pair and twiddle for butterfly number bf of a run.
  function automatic bf_addr_t bf_addr(input logic inv, input logic [3:0] bf);
    logic [1:0] layer;
    logic [1:0] j;
    logic [1:0] l2;
    logic [2:0] len;
    logic [2:0] grp;
    bf_addr_t   r;
    layer = bf[3:2];
    j     = bf[1:0];
    l2    = inv ? layer : 2'(LOG_POINTS - 1) - layer;
    len   = 3'd1 << l2;
    grp   = 3'(j) >> l2;
    r.lo  = ((grp << l2) << 1) | (3'(j) & (len - 3'd1));
    r.hi  = r.lo + len;
    if (inv) begin
      r.tw = 4'(POINTS - 1) + 4'(POINTS) - (4'(POINTS) >> layer) + 4'(grp);
    end else begin
      r.tw = ((4'd1 << layer) - 4'd1) + 4'(grp);
    end
    return r;
  endfunction

  // (a + b) mod q for operands already below q.
  function automatic coef_t add_mod(input coef_t a, input coef_t b, input coef_t q);
    logic [COEFF_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, q}) ? COEFF_BITS'(s - {1'b0, q}) : s[COEFF_BITS-1:0];
  endfunction

  // (a - b) mod q for operands already below q.
  function automatic coef_t sub_mod(input coef_t a, input coef_t b, input coef_t q);
    return (a >= b) ? a - b : COEFF_BITS'({1'b0, a} + {1'b0, q} - {1'b0, b});
  endfunction

endpackage

/* rtl/core/ntt_8_point_forward_inverse.sv */
// Eight-point number theoretic transform modulo a programmable modulus. Load
// beats emit nothing; forward and inverse beats each emit eight result beats,
// each read from the store and then loaded into the output register, which
// holds while the receiver stalls. The run time is set by the shared reduction
// unit, which retires one bit of a 48-bit dividend per cycle and serves every
// load, the pre-pass over the eight stored coefficients, each of the twelve
// butterflies and each of the eight inverse scalings. A two-entry queue in
// front lets up to two beats wait while a transform is running.
// Program modulus and inverse_scale only while the block is idle.
`include "ntt_8_point_forward_inverse_defines.svh"

module ntt_8_point_forward_inverse (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  ntt8_pkg::in_t   item,
  output logic            result_valid,
  input  logic            result_stall,
  output ntt8_pkg::out_t  result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  ntt8_pkg::coef_t cfg_data
);
  import ntt8_pkg::*;

  coef_t modulus;
  coef_t inverse_scale;
  coef_t eff_q;
  logic  head_valid;
  cmd_t  head;
  logic  pop;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus       <= MODULUS_RESET;
      inverse_scale <= INVSCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODULUS:   modulus       <= cfg_data;
        REG_INV_SCALE: inverse_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // A modulus of zero behaves as one.
  assign eff_q = (modulus == '0) ? COEFF_BITS'(1) : modulus;

  ntt8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ntt8_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q            (eff_q),
    .scale        (inverse_scale),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Checks.
  `NTT8_ASSERT_NEVER(a_pop_empty, pop && !head_valid, "queue popped while empty")
  `NTT8_ASSERT_NEVER(a_last_pos, result_valid && (result.last != (result.position == 3'd7)),
                     "last flag off the final position")
  `NTT8_ASSERT_NEXT(a_beat_gap, result_valid && !result_stall && !result.last,
                    !(result_valid && result.position == 3'd0), "run restarted mid stream")

endmodule

/* rtl/core/ntt8_front.sv */
module ntt8_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  ntt8_pkg::in_t  item,
  output logic           head_valid,
  output ntt8_pkg::cmd_t head,
  input  logic           pop
);
  import ntt8_pkg::*;

  cmd_t                 fifo [QDEPTH];
  logic [QPTR_BITS-1:0] wp;
  logic [QPTR_BITS-1:0] rp;
  logic [QPTR_BITS:0]   count;
  logic                 keep;
  logic                 push;
  cmd_t                 cmd;

  // Classify the beat and drop loads aimed outside the stores.
  always_comb begin
    cmd.slot  = item.slot;
    cmd.value = item.value;
    unique case (item.mode)
      MODE_LOAD_COEFF: begin
        cmd.op = OP_LDC;
        keep   = item.slot < 4'(POINTS);
      end
      MODE_LOAD_TWIDDLE: begin
        cmd.op = OP_LDT;
        keep   = item.slot < 4'(TWIDDLES);
      end
      MODE_FORWARD: begin
        cmd.op = OP_FWD;
        keep   = 1'b1;
      end
      default: begin
        cmd.op = OP_INV;
        keep   = 1'b1;
      end
    endcase
  end

  assign item_stall = (count == (QPTR_BITS+1)'(QDEPTH));
  assign push       = item_valid && !item_stall && keep;
  assign head_valid = (count != '0);
  assign head       = fifo[rp];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= cmd;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/ntt8_modred.sv */
module ntt8_modred (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ntt8_pkg::PROD_BITS-1:0] x,
  input  ntt8_pkg::coef_t                q,
  output logic                           done,
  output ntt8_pkg::coef_t                res
);
  import ntt8_pkg::*;

  logic [PROD_BITS-1:0]         acc;
  coef_t                        r;
  logic [$clog2(PROD_BITS)-1:0] cnt;
  logic                         busy;
  logic [COEFF_BITS:0]          shifted;
  coef_t                        r_next;

  // One dividend bit per cycle: shift in, subtract q when it fits.
  assign shifted = {r, acc[PROD_BITS-1]};
  assign r_next  = (shifted >= {1'b0, q}) ? COEFF_BITS'(shifted - {1'b0, q})
                                          : shifted[COEFF_BITS-1:0];
  assign res     = r;

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= x;
      r   <= '0;
    end else if (busy) begin
      acc <= acc << 1;
      r   <= r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(PROD_BITS))'(PROD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/ntt8_back.sv */
module ntt8_back (
  input  logic            clk,
  input  logic            rst,
  input  ntt8_pkg::coef_t q,
  input  ntt8_pkg::coef_t scale,
  input  logic            head_valid,
  input  ntt8_pkg::cmd_t  head,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_stall,
  output ntt8_pkg::out_t  result
);
  import ntt8_pkg::*;

  bstate_t              state;
  bstate_t              state_next;
  logic [3:0]           cnt;
  logic [3:0]           cnt_next;
  cmd_t                 cmd_r;
  coef_t                coef_mem [POINTS];
  coef_t                tw_mem [TWIDDLES];
  logic [2:0]           rd_a_addr;
  logic [2:0]           rd_b_addr;
  logic [3:0]           tw_addr;
  coef_t                ca_rd;
  coef_t                cb_rd;
  coef_t                tw_rd;
  logic                 cw_en;
  logic [2:0]           cw_addr;
  coef_t                cw_data;
  logic                 tw_en;
  coef_t                a_r;
  coef_t                b_r;
  coef_t                w_r;
  coef_t                sum_r;
  coef_t                diff_r;
  logic [PROD_BITS-1:0] prod_r;
  logic                 mod_start;
  logic [PROD_BITS-1:0] mod_x;
  logic                 mod_done;
  coef_t                mod_res;
  logic                 out_load;
  logic                 inv;
  bf_addr_t             ba;

  assign inv = (cmd_r.op == OP_INV);
  assign ba  = bf_addr(inv, cnt);

  ntt8_modred u_modred (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .x     (mod_x),
    .q     (q),
    .done  (mod_done),
    .res   (mod_res)
  );

  // Coefficient store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cw_en) begin
      coef_mem[cw_addr] <= cw_data;
    end
    ca_rd <= coef_mem[rd_a_addr];
    cb_rd <= coef_mem[rd_b_addr];
  end

  // Twiddle table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (tw_en) begin
      tw_mem[cmd_r.slot] <= mod_res;
    end
    tw_rd <= tw_mem[tw_addr];
  end

  // Operand and product registers.
  always_ff @(posedge clk) begin
    if (state == B_IDLE && head_valid) begin
      cmd_r <= head;
    end
    if (state == B_BF_PREP) begin
      a_r    <= ca_rd;
      b_r    <= cb_rd;
      w_r    <= tw_rd;
      sum_r  <= add_mod(ca_rd, cb_rd, q);
      diff_r <= sub_mod(ca_rd, cb_rd, q);
    end
    if (state == B_BF_MUL) begin
      prod_r <= inv ? PROD_BITS'(diff_r) * PROD_BITS'(w_r)
                    : PROD_BITS'(w_r) * PROD_BITS'(b_r);
    end
    if (state == B_SC_MUL) begin
      prod_r <= PROD_BITS'(ca_rd) * PROD_BITS'(scale);
    end
  end

  // Sequencer state and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and datapath controls.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pop        = 1'b0;
    mod_start  = 1'b0;
    mod_x      = prod_r;
    cw_en      = 1'b0;
    cw_addr    = cnt[2:0];
    cw_data    = mod_res;
    tw_en      = 1'b0;
    rd_a_addr  = cnt[2:0];
    rd_b_addr  = ba.hi;
    tw_addr    = ba.tw;
    out_load   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (head_valid) begin
          pop      = 1'b1;
          cnt_next = '0;
          if (head.op == OP_LDC || head.op == OP_LDT) begin
            state_next = B_LOAD_MOD;
          end else begin
            state_next = B_PRE_RD;
          end
        end
      end
      B_LOAD_MOD: begin
        mod_start  = 1'b1;
        mod_x      = PROD_BITS'(cmd_r.value);
        state_next = B_LOAD_WAIT;
      end
      B_LOAD_WAIT: begin
        if (mod_done) begin
          cw_en      = (cmd_r.op == OP_LDC);
          cw_addr    = cmd_r.slot[2:0];
          tw_en      = (cmd_r.op == OP_LDT);
          state_next = B_IDLE;
        end
      end
      // Bring every stored coefficient below the current modulus.
      B_PRE_RD: begin
        state_next = B_PRE_MOD;
      end
      B_PRE_MOD: begin
        mod_start  = 1'b1;
        mod_x      = PROD_BITS'(ca_rd);
        state_next = B_PRE_WAIT;
      end
      B_PRE_WAIT: begin
        if (mod_done) begin
          cw_en = 1'b1;
          if (cnt == 4'(POINTS - 1)) begin
            cnt_next   = '0;
            state_next = B_BF_RD;
          end else begin
            cnt_next   = cnt + 4'd1;
            state_next = B_PRE_RD;
          end
        end
      end
      // Butterflies, one at a time through the shared multiplier and reducer.
      B_BF_RD: begin
        rd_a_addr  = ba.lo;
        state_next = B_BF_PREP;
      end
      B_BF_PREP: begin
        state_next = B_BF_MUL;
      end
      B_BF_MUL: begin
        state_next = B_BF_MOD;
      end
      B_BF_MOD: begin
        mod_start  = 1'b1;
        state_next = B_BF_WAIT;
      end
      B_BF_WAIT: begin
        if (mod_done) begin
          state_next = B_BF_WR_A;
        end
      end
      B_BF_WR_A: begin
        cw_en      = 1'b1;
        cw_addr    = ba.lo;
        cw_data    = inv ? sum_r : add_mod(a_r, mod_res, q);
        state_next = B_BF_WR_B;
      end
      B_BF_WR_B: begin
        cw_en   = 1'b1;
        cw_addr = ba.hi;
        cw_data = inv ? mod_res : sub_mod(a_r, mod_res, q);
        if (cnt == 4'(BFLIES - 1)) begin
          cnt_next   = '0;
          state_next = inv ? B_SC_RD : B_OUT_RD;
        end else begin
          cnt_next   = cnt + 4'd1;
          state_next = B_BF_RD;
        end
      end
      // Inverse runs finish with the length scaling.
      B_SC_RD: begin
        state_next = B_SC_MUL;
      end
      B_SC_MUL: begin
        state_next = B_SC_MOD;
      end
      B_SC_MOD: begin
        mod_start  = 1'b1;
        state_next = B_SC_WAIT;
      end
      B_SC_WAIT: begin
        if (mod_done) begin
          cw_en = 1'b1;
          if (cnt == 4'(POINTS - 1)) begin
            cnt_next   = '0;
            state_next = B_OUT_RD;
          end else begin
            cnt_next   = cnt + 4'd1;
            state_next = B_SC_RD;
          end
        end
      end
      // Stream the store out, one beat per coefficient.
      B_OUT_RD: begin
        state_next = B_OUT_LD;
      end
      B_OUT_LD: begin
        if (!result_valid || !result_stall) begin
          out_load = 1'b1;
          if (cnt == 4'(POINTS - 1)) begin
            cnt_next   = '0;
            state_next = B_IDLE;
          end else begin
            cnt_next   = cnt + 4'd1;
            state_next = B_OUT_RD;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      result.coefficient <= ca_rd;
      result.position    <= cnt[2:0];
      result.last        <= (cnt == 4'(POINTS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

/* sim/ntt_8_point_forward_inverse_tb.sv */
`timescale 1ns / 100ps

module ntt_8_point_forward_inverse_tb;
  import ntt8_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int SETTLE_DELAY = 400;
  localparam int HOLD_CYCLES  = 5000;
  localparam int PHASE_BEATS  = 27;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   item_valid = 1'b0;
  logic   item_stall;
  in_t    item = '0;
  logic   result_valid;
  logic   result_stall = 1'b0;
  out_t   result;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic   cfg_index = 1'b0;
  coef_t  cfg_data = '0;

  // Beats waiting to be offered and coefficients expected back.
  in_t    pending_beats[$];
  out_t   expected_coeffs[$];

  // Shadow of the block state used to predict transform outputs.
  logic [63:0] shadow_modulus;
  logic [63:0] shadow_scale;
  logic [63:0] shadow_coeffs[POINTS];
  logic [63:0] shadow_twiddles[TWIDDLES];

  int fail_count = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  ntt_8_point_forward_inverse DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Modular helpers; a zero modulus behaves like one.
  function automatic logic [63:0] reduce_q(input logic [63:0] x);
    logic [63:0] q;
    q = (shadow_modulus == 0) ? 64'd1 : shadow_modulus;
    return x % q;
  endfunction

  function automatic logic [63:0] mul_q(input logic [63:0] x, input logic [63:0] y);
    return reduce_q(reduce_q(x) * reduce_q(y));
  endfunction

  function automatic logic [63:0] sub_q(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] q;
    logic [63:0] a;
    logic [63:0] b;
    q = (shadow_modulus == 0) ? 64'd1 : shadow_modulus;
    a = reduce_q(x);
    b = reduce_q(y);
    return (a >= b) ? a - b : a + q - b;
  endfunction

  // Apply one accepted beat to the shadow state and queue its outputs.
  task automatic ntt_predict(input in_t beat);
    int span;
    int base;
    int i;
    int tw;
    logic [63:0] w;
    logic [63:0] t;
    logic [63:0] a;
    logic [63:0] b;
    out_t o;
    case (beat.mode)
      MODE_LOAD_COEFF: begin
        if (beat.slot < POINTS) shadow_coeffs[beat.slot] = reduce_q(64'(beat.value));
      end
      MODE_LOAD_TWIDDLE: begin
        if (beat.slot < TWIDDLES) shadow_twiddles[beat.slot] = reduce_q(64'(beat.value));
      end
      MODE_FORWARD: begin
        // Cooley-Tukey layers from the widest span down.
        tw = 0;
        for (span = POINTS / 2; span >= 1; span = span / 2) begin
          for (base = 0; base < POINTS; base += 2 * span) begin
            w = shadow_twiddles[tw];
            tw++;
            for (i = base; i < base + span; i++) begin
              t = mul_q(w, shadow_coeffs[i + span]);
              a = reduce_q(shadow_coeffs[i]);
              shadow_coeffs[i + span] = sub_q(a, t);
              shadow_coeffs[i] = reduce_q(a + t);
            end
          end
        end
      end
      default: begin
        // Gentleman-Sande layers from the narrowest span up, then scaling.
        tw = POINTS - 1;
        for (span = 1; span < POINTS; span = span * 2) begin
          for (base = 0; base < POINTS; base += 2 * span) begin
            w = shadow_twiddles[tw];
            tw++;
            for (i = base; i < base + span; i++) begin
              a = reduce_q(shadow_coeffs[i]);
              b = reduce_q(shadow_coeffs[i + span]);
              shadow_coeffs[i] = reduce_q(a + b);
              shadow_coeffs[i + span] = mul_q(sub_q(a, b), w);
            end
          end
        end
        for (i = 0; i < POINTS; i++) shadow_coeffs[i] = mul_q(shadow_coeffs[i], shadow_scale);
      end
    endcase
    if (beat.mode == MODE_FORWARD || beat.mode == MODE_INVERSE) begin
      for (i = 0; i < POINTS; i++) begin
        o.coefficient = coef_t'(reduce_q(shadow_coeffs[i]));
        o.position    = 3'(i);
        o.last        = (i == POINTS - 1);
        expected_coeffs.push_back(o);
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Driver: offers queued beats, holds a stalled beat, and inserts random gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    logic held;
    held = item_valid && item_stall;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        ntt_predict(item);
        send_gap = pick_gap();
      end
      if (!held) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          item <= pending_beats.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and drives the stall pattern.
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    out_t want;
    logic nxt;
    int r;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_coeffs.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h", $time, result);
          fail_count++;
        end else begin
          want = expected_coeffs.pop_front();
          if (result.coefficient !== want.coefficient) begin
            $display("%0t: coefficient mismatch, expected %0d actual %0d", $time,
                     want.coefficient, result.coefficient);
            fail_count++;
          end
          if (result.position !== want.position) begin
            $display("%0t: position mismatch, expected %0d actual %0d", $time,
                     want.position, result.position);
            fail_count++;
          end
          if (result.last !== want.last) begin
            $display("%0t: last mismatch, expected %0d actual %0d", $time,
                     want.last, result.last);
            fail_count++;
          end
        end
      end
      // One long hold-off early in the first random phase, while beats are
      // still pending, so the input queue fills and the block stalls.
      if (!hold_done && results_seen >= 20) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        nxt = 1'b0;
        if (r >= 70) begin
          stall_left = (r >= 95) ? $urandom_range(20, 60) : $urandom_range(0, 3);
          nxt = 1'b1;
        end
      end
      result_stall <= nxt;
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready) || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ntt_8_point_forward_inverse test failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input coef_t data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MODULUS) shadow_modulus = 64'(data);
    else shadow_scale = 64'(data);
  endtask

  task automatic wait_drained();
    while (pending_beats.size() > 0 || item_valid || expected_coeffs.size() > 0)
      @(posedge clk);
    repeat (SETTLE_DELAY) @(posedge clk);
  endtask

  function automatic coef_t pick_value();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return coef_t'($urandom());
  endfunction

  function automatic in_t make_beat(input logic [1:0] m, input int s, input coef_t v);
    in_t b;
    b.mode  = m;
    b.slot  = 4'(s);
    b.value = v;
    return b;
  endfunction

  // Mostly load-then-transform sequences with random content, plus stray loads.
  task automatic queue_random_phase();
    int queued;
    int n;
    int k;
    queued = 0;
    while (queued < PHASE_BEATS) begin
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++) begin
        pending_beats.push_back(make_beat(MODE_LOAD_COEFF, $urandom_range(0, 7), pick_value()));
        queued++;
      end
      if ($urandom_range(0, 4) == 0) begin
        pending_beats.push_back(make_beat(MODE_LOAD_TWIDDLE, $urandom_range(0, 13),
                                          pick_value()));
        queued++;
      end
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1))
          pending_beats.push_back(make_beat(MODE_LOAD_COEFF, $urandom_range(8, 15),
                                            pick_value()));
        else
          pending_beats.push_back(make_beat(MODE_LOAD_TWIDDLE, $urandom_range(14, 15),
                                            pick_value()));
        queued++;
      end
      pending_beats.push_back(make_beat($urandom_range(0, 1) ? MODE_FORWARD : MODE_INVERSE,
                                        $urandom_range(0, 15), pick_value()));
      queued++;
    end
  endtask

  // Sequencer: directed beats at reset settings, then random phases per setting.
  initial begin
    int i;
    coef_t mods[5];
    coef_t scales[5];
    mods   = '{24'd12289, 24'd2, 24'hFFFFFF, 24'd0, 24'd7681};
    scales = '{24'd10753, 24'd1, 24'hFFFFFF, 24'd0, 24'd6721};
    shadow_modulus = 64'(MODULUS_RESET);
    shadow_scale   = 64'(INVSCALE_RESET);
    for (i = 0; i < POINTS; i++) shadow_coeffs[i] = '0;
    for (i = 0; i < TWIDDLES; i++) shadow_twiddles[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Every coefficient and twiddle written, extremes included, then both runs.
    for (i = 0; i < POINTS; i++)
      pending_beats.push_back(make_beat(MODE_LOAD_COEFF, i,
                                        (i == 0) ? '0 : (i == 7) ? '1 : pick_value()));
    for (i = 0; i < TWIDDLES; i++)
      pending_beats.push_back(make_beat(MODE_LOAD_TWIDDLE, i,
                                        (i == 3) ? '1 : coef_t'($urandom())));
    pending_beats.push_back(make_beat(MODE_LOAD_COEFF, 15, '1));
    pending_beats.push_back(make_beat(MODE_LOAD_TWIDDLE, 14, '1));
    pending_beats.push_back(make_beat(MODE_FORWARD, 0, '1));
    pending_beats.push_back(make_beat(MODE_INVERSE, 15, '0));
    wait_drained();

    for (i = 0; i < 5; i++) begin
      write_reg(REG_MODULUS, mods[i]);
      write_reg(REG_INV_SCALE, scales[i]);
      queue_random_phase();
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("ntt_8_point_forward_inverse test passed");
    end else begin
      $display("ntt_8_point_forward_inverse test failed");
    end
    $finish;
  end

endmodule
